>>> rtl/assert_macros.svh
// Assertion helpers shared by the evaluator modules.
// Both expect signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KEE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad evaluator assertion failed");

`define KEE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad evaluator assertion failed");

`endif

>>> rtl/kee_pkg.sv
// ----------------------------------------------------------------------------
// Keypad expression evaluator package
// Widths, key codes, command and status types shared by the evaluator.
// ----------------------------------------------------------------------------
package kee_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned Slots   = 3;
  localparam int unsigned IterW   = $clog2(DataW);

  localparam logic [KeyW-1:0] KEY_EQUAL  = 8'd61;
  localparam logic [KeyW-1:0] KEY_ENTER  = 8'd13;
  localparam logic [KeyW-1:0] KEY_PLUS   = 8'd43;
  localparam logic [KeyW-1:0] KEY_MINUS  = 8'd45;
  localparam logic [KeyW-1:0] KEY_TIMES  = 8'd42;
  localparam logic [KeyW-1:0] KEY_DIVIDE = 8'd37;
  localparam logic [KeyW-1:0] DIGIT_MAX  = 8'd9;

  localparam logic [CountW-1:0] MAX_KEYS_RESET = 9'd16;
  localparam logic [LevelW-1:0] LEVEL_TOP      = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV
  } op_code_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK, ST_SYNTAX, ST_DIV_ZERO
  } status_code_t;

  typedef enum logic [2:0] {
    KC_DIGIT, KC_ADDSUB, KC_MULDIV, KC_EQUAL, KC_ENTER, KC_OTHER
  } key_class_t;

  typedef enum logic [2:0] {
    RK_NONE, RK_ADDSUB, RK_MUL, RK_DIV, RK_DIV_ZERO
  } red_kind_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_DIGIT, CMD_SIGN, CMD_SET_OP, CMD_EQ_DROP,
    CMD_RED_SIGN, CMD_RED_OP, CMD_ITER, CMD_RED_WRITE, CMD_PUSH,
    CMD_EQ_SIGN, CMD_EMIT
  } dp_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EQ_PLAN, S_NEXT, S_SIGN, S_OP, S_ITER, S_WRITE,
    S_EQ_FIN, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_cmd_t      cmd;
    logic         take;
    logic         count;
    logic         red_idx;
    status_code_t emit_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic              closed;
    key_class_t        key_class;
    logic              digits_zero;
    logic [LevelW-1:0] level;
    logic              op0_muldiv;
    logic              red_skip;
    red_kind_t         red_kind;
    logic              iter_done;
    logic              out_free;
  } dp_stat_t;

endpackage

>>> rtl/kee_key_if.sv
// ----------------------------------------------------------------------------
// Key channel
// Carries one keypad code per request.
// ----------------------------------------------------------------------------
interface kee_key_if;
  logic                      valid;
  logic                      ready;
  logic [kee_pkg::KeyW-1:0]  key_code;
  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

>>> rtl/kee_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one evaluated value and its status per request.
// ----------------------------------------------------------------------------
interface kee_result_if;
  logic                            valid;
  logic                            ready;
  logic signed [kee_pkg::DataW-1:0] result_value;
  logic [kee_pkg::StatusW-1:0]     status;
  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

>>> rtl/kee_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Carries writes of the key limit register.
// ----------------------------------------------------------------------------
interface kee_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kee_pkg::CountW-1:0] max_keys;
  modport source (output valid, output max_keys, input ready);
  modport sink (input valid, input max_keys, output ready);
endinterface

>>> rtl/kee_datapath.sv
// ----------------------------------------------------------------------------
// Evaluator datapath
// Operand stack, counters, shift-add multiplier, restoring divider and
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kee_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  kee_pkg::dp_ctrl_t                 ctrl,
  output kee_pkg::dp_stat_t                 stat,
  input  logic                              key_valid,
  input  logic [kee_pkg::KeyW-1:0]          key_code,
  input  logic                              cfg_valid,
  input  logic [kee_pkg::CountW-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [kee_pkg::DataW-1:0]  out_value,
  output logic [kee_pkg::StatusW-1:0]       out_status
);

  logic [kee_pkg::KeyW-1:0]    key;
  logic [kee_pkg::DataW-1:0]   operand [kee_pkg::Slots];
  kee_pkg::op_code_t           opr [kee_pkg::Slots];
  logic [kee_pkg::Slots-1:0]   sgn;
  logic [kee_pkg::LevelW-1:0]  level;
  logic [kee_pkg::CountW-1:0]  digits;
  logic [kee_pkg::CountW-1:0]  keys_taken;
  logic [kee_pkg::CountW-1:0]  max_keys;
  logic [kee_pkg::DataW-1:0]   acc;
  logic [kee_pkg::DataW-1:0]   mb;
  logic [kee_pkg::DataW-1:0]   mc;
  logic [kee_pkg::IterW-1:0]   cnt;
  logic                        div_mode;
  logic                        neg;

  logic [kee_pkg::LevelW-1:0]  ia;
  logic [kee_pkg::LevelW-1:0]  ib;
  logic [kee_pkg::DataW-1:0]   va;
  logic [kee_pkg::DataW-1:0]   vb;
  logic [kee_pkg::DataW-1:0]   abs_a;
  logic [kee_pkg::DataW-1:0]   abs_b;
  logic [kee_pkg::DataW-1:0]   cur;
  logic [kee_pkg::DataW-1:0]   digit_val;
  logic [kee_pkg::DataW-1:0]   rem_s;
  logic [kee_pkg::DataW-1:0]   r_write;
  kee_pkg::op_code_t           key_op;

  assign ia  = {1'b0, ctrl.red_idx};
  assign ib  = ia + 2'd1;
  assign va  = operand[ia];
  assign vb  = operand[ib];
  assign abs_a = va[kee_pkg::DataW-1] ? (~va + 64'd1) : va;
  assign abs_b = vb[kee_pkg::DataW-1] ? (~vb + 64'd1) : vb;
  assign cur = operand[level];
  assign digit_val = (digits == '0) ? {56'd0, key}
                   : ((cur << 3) + (cur << 1) + {56'd0, key});
  assign rem_s = {acc[kee_pkg::DataW-2:0], mc[kee_pkg::DataW-1]};
  assign r_write = div_mode ? (neg ? (~mc + 64'd1) : mc) : acc;

  always_comb begin
    if (key == kee_pkg::KEY_PLUS) begin
      key_op = kee_pkg::OP_ADD;
    end else if (key == kee_pkg::KEY_MINUS) begin
      key_op = kee_pkg::OP_SUB;
    end else if (key == kee_pkg::KEY_TIMES) begin
      key_op = kee_pkg::OP_MUL;
    end else begin
      key_op = kee_pkg::OP_DIV;
    end
  end

  always_comb begin
    stat.closed = keys_taken >= max_keys;
    if (key <= kee_pkg::DIGIT_MAX) begin
      stat.key_class = kee_pkg::KC_DIGIT;
    end else if (key == kee_pkg::KEY_PLUS || key == kee_pkg::KEY_MINUS) begin
      stat.key_class = kee_pkg::KC_ADDSUB;
    end else if (key == kee_pkg::KEY_TIMES || key == kee_pkg::KEY_DIVIDE) begin
      stat.key_class = kee_pkg::KC_MULDIV;
    end else if (key == kee_pkg::KEY_EQUAL) begin
      stat.key_class = kee_pkg::KC_EQUAL;
    end else if (key == kee_pkg::KEY_ENTER) begin
      stat.key_class = kee_pkg::KC_ENTER;
    end else begin
      stat.key_class = kee_pkg::KC_OTHER;
    end
    stat.digits_zero = digits == '0;
    stat.level = level;
    stat.op0_muldiv = opr[0] == kee_pkg::OP_MUL || opr[0] == kee_pkg::OP_DIV;
    stat.red_skip = level <= ia;
    case (opr[ia])
      kee_pkg::OP_ADD, kee_pkg::OP_SUB: stat.red_kind = kee_pkg::RK_ADDSUB;
      kee_pkg::OP_MUL: stat.red_kind = kee_pkg::RK_MUL;
      kee_pkg::OP_DIV: begin
        stat.red_kind = (vb == '0) ? kee_pkg::RK_DIV_ZERO : kee_pkg::RK_DIV;
      end
      default: stat.red_kind = kee_pkg::RK_NONE;
    endcase
    stat.iter_done = cnt == '1;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < kee_pkg::Slots; k++) begin
        operand[k] <= '0;
        opr[k] <= kee_pkg::OP_NONE;
      end
      sgn <= '0;
      level <= '0;
      digits <= '0;
      keys_taken <= '0;
      max_keys <= kee_pkg::MAX_KEYS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_keys <= cfg_data;
      end
      if (ctrl.take && key_valid) begin
        key <= key_code;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.count && keys_taken != '1) begin
        keys_taken <= keys_taken + 9'd1;
      end
      case (ctrl.cmd)
        kee_pkg::CMD_CLEAR, kee_pkg::CMD_EMIT: begin
          for (int k = 0; k < kee_pkg::Slots; k++) begin
            operand[k] <= '0;
            opr[k] <= kee_pkg::OP_NONE;
          end
          sgn <= '0;
          level <= '0;
          digits <= '0;
          keys_taken <= '0;
          if (ctrl.cmd == kee_pkg::CMD_EMIT) begin
            out_valid <= 1'b1;
            out_status <= ctrl.emit_status;
            out_value <= (ctrl.emit_status == kee_pkg::ST_OK) ? operand[0] : '0;
          end
        end
        kee_pkg::CMD_DIGIT: begin
          operand[level] <= digit_val;
          if (digits != '1) begin
            digits <= digits + 9'd1;
          end
        end
        kee_pkg::CMD_SIGN: begin
          if (key == kee_pkg::KEY_MINUS) begin
            sgn[level] <= ~sgn[level];
          end
        end
        kee_pkg::CMD_SET_OP: begin
          digits <= '0;
          opr[level] <= key_op;
        end
        kee_pkg::CMD_EQ_DROP: begin
          if (level != '0 && digits == '0) begin
            level <= level - 2'd1;
          end
        end
        kee_pkg::CMD_RED_SIGN: begin
          if (sgn[ia]) begin
            operand[ia] <= ~va + 64'd1;
          end
          if (sgn[ib]) begin
            operand[ib] <= ~vb + 64'd1;
          end
          sgn[ia] <= 1'b0;
          sgn[ib] <= 1'b0;
        end
        kee_pkg::CMD_RED_OP: begin
          cnt <= '0;
          div_mode <= opr[ia] == kee_pkg::OP_DIV;
          neg <= va[kee_pkg::DataW-1] ^ vb[kee_pkg::DataW-1];
          case (opr[ia])
            kee_pkg::OP_ADD: acc <= va + vb;
            kee_pkg::OP_SUB: acc <= va - vb;
            kee_pkg::OP_MUL: begin
              acc <= '0;
              mb <= va;
              mc <= vb;
            end
            default: begin
              acc <= '0;
              mb <= abs_b;
              mc <= abs_a;
            end
          endcase
        end
        kee_pkg::CMD_ITER: begin
          cnt <= cnt + 6'd1;
          if (div_mode) begin
            if (rem_s >= mb) begin
              acc <= rem_s - mb;
              mc <= {mc[kee_pkg::DataW-2:0], 1'b1};
            end else begin
              acc <= rem_s;
              mc <= {mc[kee_pkg::DataW-2:0], 1'b0};
            end
          end else begin
            if (mc[0]) begin
              acc <= acc + mb;
            end
            mb <= mb << 1;
            mc <= mc >> 1;
          end
        end
        kee_pkg::CMD_RED_WRITE: begin
          operand[ia] <= r_write;
          opr[ia] <= opr[ib];
          if (ia == '0 && level == kee_pkg::LEVEL_TOP) begin
            operand[1] <= operand[2];
            opr[1] <= opr[2];
            sgn[1] <= sgn[2];
          end
          operand[level] <= '0;
          opr[level] <= kee_pkg::OP_NONE;
          sgn[level] <= 1'b0;
          level <= level - 2'd1;
        end
        kee_pkg::CMD_PUSH: begin
          if (level < kee_pkg::LEVEL_TOP) begin
            level <= level + 2'd1;
          end
        end
        kee_pkg::CMD_EQ_SIGN: begin
          if (sgn[0]) begin
            operand[0] <= ~operand[0] + 64'd1;
          end
          sgn[0] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  `KEE_ASSERT_IMPL(a_level_range, 1'b1, level != 2'd3)
  `KEE_ASSERT_IMPL(a_emit_free, ctrl.cmd == kee_pkg::CMD_EMIT, !out_valid || out_ready)
  `KEE_ASSERT_NEXT(a_emit_clears, ctrl.cmd == kee_pkg::CMD_EMIT, out_valid && level == '0 && keys_taken == '0)

endmodule

>>> rtl/kee_controller.sv
// ----------------------------------------------------------------------------
// Evaluator controller
// Decodes each key and sequences the reductions of the operand stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kee_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               key_valid,
  input  kee_pkg::dp_stat_t  stat,
  output kee_pkg::dp_ctrl_t  ctrl
);

  kee_pkg::ctrl_state_t  state, state_next;
  logic                  r1, r1_next;
  logic                  r0, r0_next;
  logic                  fin_eq, fin_eq_next;
  logic                  idx, idx_next;
  kee_pkg::status_code_t emit_code, emit_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kee_pkg::S_IDLE;
      r1 <= 1'b0;
      r0 <= 1'b0;
      fin_eq <= 1'b0;
      idx <= 1'b0;
      emit_code <= kee_pkg::ST_OK;
    end else begin
      state <= state_next;
      r1 <= r1_next;
      r0 <= r0_next;
      fin_eq <= fin_eq_next;
      idx <= idx_next;
      emit_code <= emit_code_next;
    end
  end

  always_comb begin
    state_next = state;
    r1_next = r1;
    r0_next = r0;
    fin_eq_next = fin_eq;
    idx_next = idx;
    emit_code_next = emit_code;
    ctrl.cmd = kee_pkg::CMD_NONE;
    ctrl.take = 1'b0;
    ctrl.count = 1'b0;
    ctrl.red_idx = idx;
    ctrl.emit_status = emit_code;
    case (state)
      kee_pkg::S_IDLE: begin
        ctrl.take = 1'b1;
        if (key_valid) begin
          state_next = kee_pkg::S_DECODE;
        end
      end
      kee_pkg::S_DECODE: begin
        state_next = kee_pkg::S_IDLE;
        if (stat.closed) begin
          if (stat.key_class == kee_pkg::KC_EQUAL) begin
            ctrl.cmd = kee_pkg::CMD_EQ_DROP;
            state_next = kee_pkg::S_EQ_PLAN;
          end else if (stat.key_class == kee_pkg::KC_ENTER) begin
            ctrl.cmd = kee_pkg::CMD_CLEAR;
          end
        end else begin
          ctrl.count = 1'b1;
          case (stat.key_class)
            kee_pkg::KC_DIGIT: ctrl.cmd = kee_pkg::CMD_DIGIT;
            kee_pkg::KC_ADDSUB: begin
              if (stat.digits_zero) begin
                ctrl.cmd = kee_pkg::CMD_SIGN;
              end else begin
                ctrl.cmd = kee_pkg::CMD_SET_OP;
                r1_next = stat.level == kee_pkg::LEVEL_TOP;
                r0_next = stat.level != '0;
                fin_eq_next = 1'b0;
                state_next = kee_pkg::S_NEXT;
              end
            end
            kee_pkg::KC_MULDIV: begin
              if (stat.digits_zero) begin
                emit_code_next = kee_pkg::ST_SYNTAX;
                state_next = kee_pkg::S_EMIT;
              end else begin
                ctrl.cmd = kee_pkg::CMD_SET_OP;
                r1_next = stat.level == kee_pkg::LEVEL_TOP;
                r0_next = stat.level == 2'd1 && stat.op0_muldiv;
                fin_eq_next = 1'b0;
                state_next = kee_pkg::S_NEXT;
              end
            end
            kee_pkg::KC_EQUAL: begin
              ctrl.cmd = kee_pkg::CMD_EQ_DROP;
              state_next = kee_pkg::S_EQ_PLAN;
            end
            kee_pkg::KC_ENTER: ctrl.cmd = kee_pkg::CMD_CLEAR;
            default: begin
            end
          endcase
        end
      end
      kee_pkg::S_EQ_PLAN: begin
        r1_next = stat.level == kee_pkg::LEVEL_TOP;
        r0_next = stat.level != '0;
        fin_eq_next = 1'b1;
        state_next = kee_pkg::S_NEXT;
      end
      kee_pkg::S_NEXT: begin
        if (r1) begin
          r1_next = 1'b0;
          idx_next = 1'b1;
          state_next = kee_pkg::S_SIGN;
        end else if (r0) begin
          r0_next = 1'b0;
          idx_next = 1'b0;
          state_next = kee_pkg::S_SIGN;
        end else if (fin_eq) begin
          state_next = kee_pkg::S_EQ_FIN;
        end else begin
          ctrl.cmd = kee_pkg::CMD_PUSH;
          state_next = kee_pkg::S_IDLE;
        end
      end
      kee_pkg::S_SIGN: begin
        if (stat.red_skip) begin
          state_next = kee_pkg::S_NEXT;
        end else begin
          ctrl.cmd = kee_pkg::CMD_RED_SIGN;
          state_next = kee_pkg::S_OP;
        end
      end
      kee_pkg::S_OP: begin
        case (stat.red_kind)
          kee_pkg::RK_ADDSUB: begin
            ctrl.cmd = kee_pkg::CMD_RED_OP;
            state_next = kee_pkg::S_WRITE;
          end
          kee_pkg::RK_MUL, kee_pkg::RK_DIV: begin
            ctrl.cmd = kee_pkg::CMD_RED_OP;
            state_next = kee_pkg::S_ITER;
          end
          kee_pkg::RK_DIV_ZERO: begin
            emit_code_next = kee_pkg::ST_DIV_ZERO;
            state_next = kee_pkg::S_EMIT;
          end
          default: state_next = kee_pkg::S_NEXT;
        endcase
      end
      kee_pkg::S_ITER: begin
        ctrl.cmd = kee_pkg::CMD_ITER;
        if (stat.iter_done) begin
          state_next = kee_pkg::S_WRITE;
        end
      end
      kee_pkg::S_WRITE: begin
        ctrl.cmd = kee_pkg::CMD_RED_WRITE;
        state_next = kee_pkg::S_NEXT;
      end
      kee_pkg::S_EQ_FIN: begin
        ctrl.cmd = kee_pkg::CMD_EQ_SIGN;
        emit_code_next = kee_pkg::ST_OK;
        state_next = kee_pkg::S_EMIT;
      end
      kee_pkg::S_EMIT: begin
        if (stat.out_free) begin
          ctrl.cmd = kee_pkg::CMD_EMIT;
          state_next = kee_pkg::S_IDLE;
        end
      end
      default: state_next = kee_pkg::S_IDLE;
    endcase
  end

  `KEE_ASSERT_NEXT(a_iter_hold, state == kee_pkg::S_ITER && !stat.iter_done, state == kee_pkg::S_ITER)

endmodule

>>> rtl/keypad_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Keypad expression evaluator
// Evaluates integer expressions typed one key per request.
// ----------------------------------------------------------------------------
// One key request is taken at a time. A digit, sign, Enter or ignored key
// needs only the idle and decode states. An operator or Equal adds up to two
// stack reductions: an add or subtract runs the sign, op and write states, a
// multiply or divide also the 64-step shift-add multiplier or restoring
// divider. At most one of the two reductions is a multiply or divide, so the
// slowest key is an Equal that runs one of each and may then wait for the
// result channel to free up. A finished result waits in its own register
// while the next key is already taken. The limit register may be written at
// any time the block is idle and is always ready.

module keypad_expression_evaluator_unit (
  input  logic  clk,
  input  logic  rst,
  kee_key_if.sink      key,
  kee_result_if.source result,
  kee_cfg_if.sink      cfg
);

  kee_pkg::dp_ctrl_t ctrl;
  kee_pkg::dp_stat_t stat;

  assign key.ready = ctrl.take;
  assign cfg.ready = 1'b1;

  kee_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key.valid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  kee_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .key_valid  (key.valid),
    .key_code   (key.key_code),
    .cfg_valid  (cfg.valid),
    .cfg_data   (cfg.max_keys),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_value  (result.result_value),
    .out_status (result.status)
  );

endmodule

>>> verif/keypad_expression_evaluator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad expression evaluator test
// Sends directed and random key requests, with random stalls on the key and
// result channels, and writes the key limit between phases. A scoreboard
// predicts each result and compares it field by field with the block.
// ----------------------------------------------------------------------------

class kee_scoreboard;
  logic [kee_pkg::DataW-1:0]  opnd [kee_pkg::Slots];
  kee_pkg::op_code_t          opr [kee_pkg::Slots];
  logic                       neg [kee_pkg::Slots];
  int unsigned                level;
  int unsigned                digits;
  int unsigned                taken;
  int unsigned                limit;
  logic [kee_pkg::DataW-1:0]  want_value [$];
  kee_pkg::status_code_t      want_status [$];
  int unsigned                errors;

  function new();
    limit = kee_pkg::MAX_KEYS_RESET;
    errors = 0;
    clear();
  endfunction

  function void clear();
    for (int k = 0; k < kee_pkg::Slots; k++) begin
      opnd[k] = '0;
      opr[k] = kee_pkg::OP_NONE;
      neg[k] = 1'b0;
    end
    level = 0;
    digits = 0;
    taken = 0;
  endfunction

  function void post(logic [kee_pkg::DataW-1:0] v, kee_pkg::status_code_t s);
    want_value.push_back(v);
    want_status.push_back(s);
    clear();
  endfunction

  function logic [kee_pkg::DataW-1:0] quotient(logic [kee_pkg::DataW-1:0] a,
                                               logic [kee_pkg::DataW-1:0] b);
    logic [kee_pkg::DataW-1:0] ma, mb, q;
    ma = a[kee_pkg::DataW-1] ? -a : a;
    mb = b[kee_pkg::DataW-1] ? -b : b;
    q = ma / mb;
    return (a[kee_pkg::DataW-1] != b[kee_pkg::DataW-1]) ? -q : q;
  endfunction

  // Returns 1 on a division by zero.
  function bit fold(int unsigned i);
    logic [kee_pkg::DataW-1:0] a, b, r;
    if (i > 1 || level <= i) return 0;
    if (neg[i]) begin opnd[i] = -opnd[i]; neg[i] = 0; end
    if (neg[i+1]) begin opnd[i+1] = -opnd[i+1]; neg[i+1] = 0; end
    a = opnd[i];
    b = opnd[i+1];
    case (opr[i])
      kee_pkg::OP_ADD: r = a + b;
      kee_pkg::OP_SUB: r = a - b;
      kee_pkg::OP_MUL: r = a * b;
      kee_pkg::OP_DIV: begin
        if (b == 0) return 1;
        r = quotient(a, b);
      end
      default: return 0;
    endcase
    opnd[i] = r;
    opr[i] = opr[i+1];
    if (i == 0 && level == 2) begin
      opnd[1] = opnd[2];
      opr[1] = opr[2];
      neg[1] = neg[2];
    end
    opnd[level] = '0;
    opr[level] = kee_pkg::OP_NONE;
    neg[level] = 0;
    level--;
    return 0;
  endfunction

  function void equal();
    bit e;
    e = 0;
    if (level > 0 && digits == 0) level--;
    if (level == 1) e = fold(0);
    else if (level == 2) begin
      e = fold(1);
      if (!e) e = fold(0);
    end
    if (e) begin post('0, kee_pkg::ST_DIV_ZERO); return; end
    if (neg[0]) opnd[0] = -opnd[0];
    post(opnd[0], kee_pkg::ST_OK);
  endfunction

  function void note_key(logic [kee_pkg::KeyW-1:0] key);
    int unsigned lvl;
    bit e;
    e = 0;
    if (taken >= limit) begin
      if (key == kee_pkg::KEY_EQUAL) equal();
      else if (key == kee_pkg::KEY_ENTER) clear();
      return;
    end
    if (taken < 511) taken++;
    lvl = (level > 2) ? 2 : level;
    if (key <= kee_pkg::DIGIT_MAX) begin
      opnd[lvl] = (digits == 0) ? kee_pkg::DataW'(key)
                                : opnd[lvl] * 10 + kee_pkg::DataW'(key);
      if (digits < 511) digits++;
    end else if (key == kee_pkg::KEY_PLUS || key == kee_pkg::KEY_MINUS) begin
      if (digits == 0) begin
        if (key == kee_pkg::KEY_MINUS) neg[lvl] = ~neg[lvl];
      end else begin
        digits = 0;
        opr[lvl] = (key == kee_pkg::KEY_PLUS) ? kee_pkg::OP_ADD : kee_pkg::OP_SUB;
        if (lvl == 1) e = fold(0);
        else if (lvl == 2) begin
          e = fold(1);
          if (!e) e = fold(0);
        end
        if (e) begin post('0, kee_pkg::ST_DIV_ZERO); return; end
        if (level < 2) level++;
      end
    end else if (key == kee_pkg::KEY_TIMES || key == kee_pkg::KEY_DIVIDE) begin
      if (digits == 0) begin post('0, kee_pkg::ST_SYNTAX); return; end
      digits = 0;
      opr[lvl] = (key == kee_pkg::KEY_TIMES) ? kee_pkg::OP_MUL : kee_pkg::OP_DIV;
      if (lvl == 1) begin
        if (opr[0] == kee_pkg::OP_MUL || opr[0] == kee_pkg::OP_DIV) e = fold(0);
      end else if (lvl == 2) e = fold(1);
      if (e) begin post('0, kee_pkg::ST_DIV_ZERO); return; end
      if (level < 2) level++;
    end else if (key == kee_pkg::KEY_EQUAL) equal();
    else if (key == kee_pkg::KEY_ENTER) clear();
  endfunction

  function void check_result(logic [kee_pkg::DataW-1:0] v,
                             logic [kee_pkg::StatusW-1:0] s);
    if (want_value.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d status %0d", $signed(v), s));
      return;
    end
    if (v !== want_value[0])
      report_mismatch($sformatf("result_value %0d, predicted %0d", $signed(v),
                                $signed(want_value[0])));
    if (s !== want_status[0])
      report_mismatch($sformatf("status %0d, predicted %0d", s, want_status[0]));
    void'(want_value.pop_front());
    void'(want_status.pop_front());
  endfunction

  function void report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endfunction
endclass

module keypad_expression_evaluator_unit_test;
  logic clk = 1'b0;
  logic rst = 1'b1;
  kee_key_if    key_ch ();
  kee_result_if res_ch ();
  kee_cfg_if    cfg_ch ();
  kee_scoreboard board = new();
  bit calm = 0;

  keypad_expression_evaluator_unit u_top (
    .clk(clk), .rst(rst), .key(key_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  initial begin
    key_ch.valid = 1'b0;
    key_ch.key_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_keys = '0;
    res_ch.ready = 1'b0;
  end

  // Result side with random stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        board.check_result(res_ch.result_value, res_ch.status);
      if (!calm && $urandom_range(0, 9) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk) begin
          if (res_ch.valid && res_ch.ready)
            board.check_result(res_ch.result_value, res_ch.status);
        end
        res_ch.ready <= 1'b1;
      end else
        res_ch.ready <= 1'b1;
    end
  end

  task automatic send_key(logic [kee_pkg::KeyW-1:0] k);
    if (!calm && $urandom_range(0, 7) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.key_code <= k;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    board.note_key(k);
  endtask

  task automatic drain();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.want_value.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned n);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_keys <= kee_pkg::CountW'(n);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.limit = n;
  endtask

  task automatic send_number(int unsigned ndig);
    if ($urandom_range(0, 3) == 0) send_key(kee_pkg::KEY_MINUS);
    for (int i = 0; i < ndig; i++) send_key(kee_pkg::KeyW'($urandom_range(0, 9)));
  endtask

  function automatic logic [kee_pkg::KeyW-1:0] pick_op();
    case ($urandom_range(0, 3))
      0: return kee_pkg::KEY_PLUS;
      1: return kee_pkg::KEY_MINUS;
      2: return kee_pkg::KEY_TIMES;
      default: return kee_pkg::KEY_DIVIDE;
    endcase
  endfunction

  task automatic send_expr();
    int unsigned terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) send_key(pick_op());
      send_number(($urandom_range(0, 15) == 0) ? 20 : $urandom_range(1, 3));
    end
    if ($urandom_range(0, 9) == 0) send_key(pick_op());
    send_key(kee_pkg::KEY_EQUAL);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) send_key(kee_pkg::KeyW'($urandom_range(0, 255)));
    send_key(($urandom_range(0, 3) == 0) ? kee_pkg::KEY_ENTER : kee_pkg::KEY_EQUAL);
  endtask

  string big_num = "9223372036854775808";

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part.
    send_key(kee_pkg::KEY_EQUAL);
    send_key(kee_pkg::KEY_TIMES);
    send_key(kee_pkg::KEY_MINUS); send_key(8'd7); send_key(kee_pkg::KEY_EQUAL);
    send_key(8'd9); send_key(kee_pkg::KEY_DIVIDE); send_key(8'd0);
    send_key(kee_pkg::KEY_EQUAL);
    send_key(8'd2); send_key(kee_pkg::KEY_PLUS); send_key(8'd3);
    send_key(kee_pkg::KEY_TIMES);
    send_key(8'd4); send_key(kee_pkg::KEY_MINUS); send_key(kee_pkg::KEY_EQUAL);
    send_key(8'd8); send_key(kee_pkg::KEY_ENTER); send_key(8'hFF);
    send_key(kee_pkg::KEY_PLUS);
    send_key(8'd5); send_key(kee_pkg::KEY_EQUAL);
    // Long digit run saturates the limit at its reset value.
    for (int i = 0; i < 20; i++) send_key(8'd9);
    send_key(kee_pkg::KEY_EQUAL);
    set_limit(0);
    send_key(8'd3); send_key(kee_pkg::KEY_ENTER); send_key(kee_pkg::KEY_EQUAL);
    set_limit(511);
    // Most negative value divided by minus one.
    send_key(kee_pkg::KEY_MINUS);
    foreach (big_num[i]) send_key(kee_pkg::KeyW'(big_num[i] - 8'd48));
    send_key(kee_pkg::KEY_DIVIDE); send_key(kee_pkg::KEY_MINUS); send_key(8'd1);
    send_key(kee_pkg::KEY_EQUAL);
    // Random part over several limits.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_limit(1);
        1: set_limit(256);
        2: set_limit($urandom_range(2, 30));
        3: set_limit(511);
        default: set_limit($urandom_range(1, 64));
      endcase
      for (int i = 0; i < 34; i++) begin
        if (ph == 5 && i == 17) calm = 1;
        if (i == 10) drain();
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_expr();
      end
    end
    drain();
    if (board.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
